// ===== rtl/core/txe_pkg.sv =====
// Package for the transaction extra key and payment id extractor.
// Holds the shared constants, codes and structs; it depends on nothing.
package txe_pkg;

    localparam int MAX_EXTRA_BYTES = 1024;
    localparam int FIELD_BYTES     = 32;
    localparam int FIELD_WORDS     = FIELD_BYTES / 8;

    // Width of bytes_left: it must hold MAX_EXTRA_BYTES itself.
    localparam int BL_W  = $clog2(MAX_EXTRA_BYTES) + 1;
    // A held byte's remaining count is bytes_left plus up to two.
    localparam int REM_W = BL_W + 1;

    localparam int SKIP_W = 6;
    localparam int IDX_W  = 5;

    // Configuration register indexes.
    localparam logic [7:0] REG_PUBKEY_TAG     = 8'd0;
    localparam logic [7:0] REG_NONCE_TAG      = 8'd1;
    localparam logic [7:0] REG_PAYMENT_ID_TAG = 8'd2;

    typedef enum logic [1:0] {
        CAP_NONE = 2'd0,
        CAP_KEY  = 2'd1,
        CAP_ID   = 2'd2
    } cap_target_t;

    typedef struct packed {
        logic [7:0] pubkey;
        logic [7:0] nonce;
        logic [7:0] pay_id;
    } tags_t;

    // Field results handed from the scanner to the emitter on a final byte.
    typedef struct packed {
        logic                        load;
        logic                        key_seen;
        logic                        id_seen;
        logic [FIELD_WORDS-1:0][63:0] key;
        logic [FIELD_WORDS-1:0][63:0] id;
    } txe_snap_t;

endpackage

// ===== rtl/core/txe_scanner.sv =====
// Byte scanner: two-byte lookahead window, skip and capture state, field stores.
// Depends on txe_pkg for constants and the snapshot struct.
module txe_scanner (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [7:0]               data_byte,
    input  logic [txe_pkg::BL_W-1:0] bytes_left,
    input  txe_pkg::tags_t           tags,
    input  logic                     out_busy,
    output txe_pkg::txe_snap_t       snap
);
    import txe_pkg::*;

    typedef struct packed {
        logic [SKIP_W-1:0]            skip;
        cap_target_t                  target;
        logic [IDX_W-1:0]             cap_idx;
        logic                         key_seen;
        logic                         id_seen;
        logic [FIELD_WORDS-1:0][63:0] key;
        logic [FIELD_WORDS-1:0][63:0] id;
    } scan_state_t;

    // Decision for one byte c with rem bytes remaining; b2 is two bytes ahead.
    function automatic scan_state_t decide(scan_state_t s, logic [7:0] c,
                                           logic [REM_W-1:0] rem, logic [7:0] b2,
                                           logic b2_ok, tags_t t);
        scan_state_t r;
        logic [IDX_W-1:0] idx;
        logic [63:0] lane;
        r    = s;
        idx  = s.cap_idx;
        lane = {56'd0, c} << {3'd7 - idx[2:0], 3'b000};
        if (s.skip != '0)
        begin
            if (s.skip <= SKIP_W'(FIELD_BYTES) && s.target != CAP_NONE)
            begin
                if (s.target == CAP_KEY)
                begin
                    r.key[idx[4:3]] = s.key[idx[4:3]] | lane;
                end
                else
                begin
                    r.id[idx[4:3]] = s.id[idx[4:3]] | lane;
                end
                r.cap_idx = idx + IDX_W'(1);
            end
            r.skip = s.skip - SKIP_W'(1);
            if (r.skip == '0)
            begin
                r.target = CAP_NONE;
            end
        end
        else if (c == t.pubkey && rem > REM_W'(FIELD_BYTES) && !s.key_seen)
        begin
            r.key_seen = 1'b1;
            r.target   = CAP_KEY;
            r.cap_idx  = '0;
            r.skip     = SKIP_W'(FIELD_BYTES);
        end
        else if (c == t.nonce && rem > REM_W'(FIELD_BYTES + 2) && b2_ok &&
                 b2 == t.pay_id && !s.id_seen)
        begin
            r.id_seen = 1'b1;
            r.target  = CAP_ID;
            r.cap_idx = '0;
            r.skip    = SKIP_W'(FIELD_BYTES + 2);
        end
        return r;
    endfunction

    scan_state_t state_reg, state_next;
    logic [7:0]  win0_reg, win0_next;
    logic [7:0]  win1_reg, win1_next;
    logic [1:0]  fill_reg, fill_next;

    logic        is_final;
    logic        accept;
    scan_state_t s_a, s_b, s_c;

    assign is_final = bytes_left <= BL_W'(1);
    // A final byte waits until the previous result words have all left.
    assign in_stall = out_busy && is_final;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        state_next = state_reg;
        win0_next  = win0_reg;
        win1_next  = win1_reg;
        fill_next  = fill_reg;
        snap       = '0;
        s_a        = state_reg;
        s_b        = state_reg;
        s_c        = state_reg;
        if (accept && !is_final)
        begin
            if (fill_reg == 2'd2)
            begin
                state_next = decide(state_reg, win0_reg, REM_W'(bytes_left) + REM_W'(2),
                                    data_byte, 1'b1, tags);
                win0_next  = win1_reg;
                win1_next  = data_byte;
            end
            else if (fill_reg == 2'd1)
            begin
                win1_next = data_byte;
                fill_next = 2'd2;
            end
            else
            begin
                win0_next = data_byte;
                fill_next = 2'd1;
            end
        end
        else if (accept)
        begin
            // Flush the window, then the final byte itself.
            if (fill_reg != 2'd0)
            begin
                s_a = decide(state_reg, win0_reg, REM_W'(fill_reg) + REM_W'(1),
                             data_byte, fill_reg == 2'd2, tags);
            end
            s_b = s_a;
            if (fill_reg == 2'd2)
            begin
                s_b = decide(s_a, win1_reg, REM_W'(2), 8'd0, 1'b0, tags);
            end
            s_c = decide(s_b, data_byte, REM_W'(1), 8'd0, 1'b0, tags);
            snap.load     = 1'b1;
            snap.key_seen = s_c.key_seen;
            snap.id_seen  = s_c.id_seen;
            snap.key      = s_c.key;
            snap.id       = s_c.id;
            state_next    = '0;
            win0_next     = '0;
            win1_next     = '0;
            fill_next     = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
            win0_reg  <= '0;
            win1_reg  <= '0;
            fill_reg  <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            win0_reg  <= win0_next;
            win1_reg  <= win1_next;
            fill_reg  <= fill_next;
        end
    end

endmodule

// ===== rtl/core/txe_emitter.sv =====
// Result buffer that sends the eight key and id words of one stream.
// Depends on txe_pkg for the snapshot struct.
module txe_emitter (
    input  logic               clk,
    input  logic               rst_n,
    input  txe_pkg::txe_snap_t snap,
    output logic               busy,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               field_kind,
    output logic [1:0]         word_index,
    output logic [63:0]        word_data,
    output logic               found,
    output logic               last_word
);
    import txe_pkg::*;

    logic                         busy_reg, busy_next;
    logic [2:0]                   word_reg, word_next;
    logic                         key_seen_reg;
    logic                         id_seen_reg;
    logic [FIELD_WORDS-1:0][63:0] key_reg;
    logic [FIELD_WORDS-1:0][63:0] id_reg;
    logic                         take;

    assign busy       = busy_reg;
    assign out_valid  = busy_reg;
    assign take       = busy_reg && !out_stall;
    assign field_kind = word_reg[2];
    assign word_index = word_reg[1:0];
    assign word_data  = word_reg[2] ? id_reg[word_reg[1:0]] : key_reg[word_reg[1:0]];
    assign found      = word_reg[2] ? id_seen_reg : key_seen_reg;
    assign last_word  = word_reg == 3'd7;

    always_comb
    begin
        busy_next = busy_reg;
        word_next = word_reg;
        if (snap.load)
        begin
            busy_next = 1'b1;
            word_next = 3'd0;
        end
        else if (take)
        begin
            word_next = word_reg + 3'd1;
            if (word_reg == 3'd7)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            word_reg <= 3'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            word_reg <= word_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (snap.load)
        begin
            key_seen_reg <= snap.key_seen;
            id_seen_reg  <= snap.id_seen;
            key_reg      <= snap.key;
            id_reg       <= snap.id;
        end
    end

endmodule

// ===== rtl/core/tx_extra_key_and_id_extractor_top.sv =====
// The first result word of a stream shows the cycle after its final byte.
// Throughput: one byte request per cycle; the eight result words go out one per cycle unless stalled.
// A final byte is held off while the previous stream's eight words are still leaving,
// which the emitter's single result buffer sets.
// Reset (rst_n, asynchronous, active low) clears the scan state and loads the tag
// registers with pubkey 1, nonce 2, payment id 0.
module tx_extra_key_and_id_extractor_top (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [7:0]               data_byte,
    input  logic [txe_pkg::BL_W-1:0] bytes_left,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic                     field_kind,
    output logic [1:0]               word_index,
    output logic [63:0]              word_data,
    output logic                     found,
    output logic                     last_word,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [7:0]               cfg_index,
    input  logic [7:0]               cfg_data
);
    import txe_pkg::*;

    // The tag registers. Writes to an index past the list are accepted and dropped.
    tags_t     tags_reg, tags_next;
    txe_snap_t snap;
    logic      out_busy;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        tags_next = tags_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_PUBKEY_TAG:     tags_next.pubkey = cfg_data;
                REG_NONCE_TAG:      tags_next.nonce  = cfg_data;
                REG_PAYMENT_ID_TAG: tags_next.pay_id = cfg_data;
                default:            tags_next = tags_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tags_reg.pubkey <= 8'd1;
            tags_reg.nonce  <= 8'd2;
            tags_reg.pay_id <= 8'd0;
        end
        else
        begin
            tags_reg <= tags_next;
        end
    end

    // The scanner decides each byte two requests late, once the byte two places
    // ahead is known, and flushes its window on the final byte.
    txe_scanner u_scanner (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .data_byte  (data_byte),
        .bytes_left (bytes_left),
        .tags       (tags_reg),
        .out_busy   (out_busy),
        .snap       (snap)
    );

    // The emitter holds a copy of both fields so the next stream can start at once.
    txe_emitter u_emitter (
        .clk        (clk),
        .rst_n      (rst_n),
        .snap       (snap),
        .busy       (out_busy),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .field_kind (field_kind),
        .word_index (word_index),
        .word_data  (word_data),
        .found      (found),
        .last_word  (last_word)
    );

endmodule

// ===== rtl/core/txe_checker.sv =====
// Port-level checks for the extractor, bound to the top level.
// Depends on txe_pkg for the bytes_left width.
module txe_checker (
    input logic                     clk,
    input logic                     rst_n,
    input logic                     in_valid,
    input logic                     in_stall,
    input logic [7:0]               data_byte,
    input logic [txe_pkg::BL_W-1:0] bytes_left,
    input logic                     out_valid,
    input logic                     out_stall,
    input logic                     field_kind,
    input logic [1:0]               word_index,
    input logic [63:0]              word_data,
    input logic                     found,
    input logic                     last_word,
    input logic                     cfg_valid,
    input logic                     cfg_ready,
    input logic [7:0]               cfg_index,
    input logic [7:0]               cfg_data
);
    import txe_pkg::*;

    // A stalled result word holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(word_data) && $stable(word_index))
        else $error("stalled result word changed");

    // The last word is the fourth payment id word.
    a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last_word |-> field_kind && word_index == 2'd3)
        else $error("last word out of place");

    // Once started, the eight words follow without a gap.
    a_burst: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last_word |=> out_valid)
        else $error("gap inside a result burst");

    // A field that never occurred reads as zero.
    a_absent_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found |-> word_data == 64'd0)
        else $error("absent field has nonzero data");

endmodule

bind tx_extra_key_and_id_extractor_top txe_checker u_txe_checker (.*);
